/* rtl/mafl_pkg.sv */
// Package for the masked address filter table.
// Sizes, entry record, request opcodes and sequencer states; no dependencies.
package mafl_pkg;

  localparam int MASK_GROUPS  = 8;
  localparam int RULE_ENTRIES = 64;
  localparam int ADDR_W       = 32;
  localparam int VERD_W       = 2;
  localparam int OP_W         = 2;

  localparam int GRP_W = (MASK_GROUPS > 1) ? $clog2(MASK_GROUPS) : 1;
  localparam int CNT_W = $clog2(MASK_GROUPS + 1);
  localparam int IDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_CHECK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GSCAN,
    ST_ESCAN,
    ST_EDRAIN,
    ST_WRITE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] key;
    logic [GRP_W-1:0]  grp;
    logic [VERD_W-1:0] verdict;
  } entry_t;

endpackage

/* rtl/mafl_if.sv */
// Request and result channel interfaces for the masked address filter table.
// Depends on mafl_pkg for field widths.
interface mafl_req_if;
  logic                        valid;
  logic                        ready;
  logic [mafl_pkg::OP_W-1:0]   operation;
  logic [mafl_pkg::ADDR_W-1:0] address;
  logic [mafl_pkg::ADDR_W-1:0] rule_mask;
  logic [mafl_pkg::VERD_W-1:0] rule_verdict;

  modport source (output valid, operation, address, rule_mask, rule_verdict, input ready);
  modport sink   (input valid, operation, address, rule_mask, rule_verdict, output ready);
endinterface

interface mafl_res_if;
  logic                        valid;
  logic                        ready;
  logic [mafl_pkg::VERD_W-1:0] verdict;
  logic                        matched;
  logic                        refused;

  modport source (output valid, verdict, matched, refused, input ready);
  modport sink   (input valid, verdict, matched, refused, output ready);
endinterface

/* rtl/mafl_entry_ram.sv */
// Rule entry store: one write port, one registered read port.
// Depends on mafl_pkg for the entry record and depth.
module mafl_entry_ram (
  input  logic                   clk,
  input  logic                   we,
  input  logic [mafl_pkg::IDX_W-1:0] waddr,
  input  mafl_pkg::entry_t       wdata,
  input  logic [mafl_pkg::IDX_W-1:0] raddr,
  output mafl_pkg::entry_t       rdata
);
  import mafl_pkg::*;

  entry_t mem [RULE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mafl_match.sv */
// Shared masked compare unit: (a AND m) equals b.
// Depends on mafl_pkg for the address width.
module mafl_match (
  input  logic [mafl_pkg::ADDR_W-1:0] a,
  input  logic [mafl_pkg::ADDR_W-1:0] m,
  input  logic [mafl_pkg::ADDR_W-1:0] b,
  output logic                        eq
);
  import mafl_pkg::*;

  assign eq = ((a & m) == b);

endmodule

/* rtl/masked_address_filter_table.sv */
// Masked address filter table: top level with the sequencer, group masks and valid bits.
// Depends on mafl_pkg, mafl_if, mafl_entry_ram and mafl_match.
//
// Usage:
//   in_req carries one request: clear, add rule or check address. out_res returns
//   exactly one result per request (verdict, matched, refused).
//   A request is taken only while the sequencer is idle. A clear or unused opcode
//   goes straight to the response state. A check walks the entry store once, one
//   entry per cycle through the single RAM read port. An add first steps through
//   the mask groups in use, one per cycle on the shared compare unit, then, unless
//   a new mask finds the group store full, walks the entry store and writes.
//   Reset empties the table at once (group count and entry valid bits cleared);
//   no clearing pass is needed.
//   The result sits in an output register. While it waits, the next request can
//   be taken; a finished result held up by a stalled receiver holds the
//   sequencer in its response state until the register frees.
module masked_address_filter_table (
  input  logic       clk,
  input  logic       rst_n,
  mafl_req_if.sink   in_req,
  mafl_res_if.source out_res
);
  import mafl_pkg::*;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ADDR_W-1:0] opa_r, opa_nxt;
  logic [ADDR_W-1:0] mask_r, mask_nxt;
  logic [VERD_W-1:0] verd_r, verd_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [RULE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [ADDR_W-1:0]       gm_r [MASK_GROUPS];

  logic [GRP_W-1:0] g_idx_r, g_idx_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic             new_r, new_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             pipe_v_r, pipe_v_nxt;
  logic [IDX_W-1:0] pipe_idx_r, pipe_idx_nxt;

  logic              best_found_r, best_found_nxt;
  logic [GRP_W-1:0]  best_grp_r, best_grp_nxt;
  logic [VERD_W-1:0] best_verd_r, best_verd_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic              refused_r, refused_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [VERD_W-1:0] out_verdict_r, out_verdict_nxt;
  logic              out_matched_r, out_matched_nxt;
  logic              out_refused_r, out_refused_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rd;
  entry_t           ram_wd;

  logic             gm_we;
  logic [GRP_W-1:0] gm_addr;
  logic [ADDR_W-1:0] gm_rd;

  logic [ADDR_W-1:0] cmp_a, cmp_m, cmp_b;
  logic              cmp_eq;
  logic              ent_valid;

  mafl_entry_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wd),
    .raddr (ram_raddr),
    .rdata (ram_rd)
  );

  mafl_match u_match (
    .a  (cmp_a),
    .m  (cmp_m),
    .b  (cmp_b),
    .eq (cmp_eq)
  );

  assign ram_wd   = '{key: opa_r, grp: grp_r, verdict: verd_r};
  assign gm_addr  = (state_r == ST_GSCAN) ? g_idx_r : ram_rd.grp;
  assign gm_rd    = gm_r[gm_addr];
  assign ent_valid = valid_r[pipe_idx_r];

  // Shared compare: group search, or masked key against the entry read back.
  always_comb begin
    if (state_r == ST_GSCAN) begin
      cmp_a = mask_r;
      cmp_m = '1;
      cmp_b = gm_rd;
    end else begin
      cmp_a = opa_r;
      cmp_m = (op_r == OP_CHECK) ? gm_rd : '1;
      cmp_b = ram_rd.key;
    end
  end

  assign in_req.ready    = (state_r == ST_IDLE);
  assign out_res.valid   = out_valid_r;
  assign out_res.verdict = out_verdict_r;
  assign out_res.matched = out_matched_r;
  assign out_res.refused = out_refused_r;

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    opa_nxt         = opa_r;
    mask_nxt        = mask_r;
    verd_nxt        = verd_r;
    count_nxt       = count_r;
    valid_nxt       = valid_r;
    g_idx_nxt       = g_idx_r;
    grp_nxt         = grp_r;
    new_nxt         = new_r;
    scan_idx_nxt    = scan_idx_r;
    pipe_v_nxt      = pipe_v_r;
    pipe_idx_nxt    = pipe_idx_r;
    best_found_nxt  = best_found_r;
    best_grp_nxt    = best_grp_r;
    best_verd_nxt   = best_verd_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    refused_nxt     = refused_r;
    out_valid_nxt   = out_valid_r;
    out_verdict_nxt = out_verdict_r;
    out_matched_nxt = out_matched_r;
    out_refused_nxt = out_refused_r;
    ram_we          = 1'b0;
    ram_waddr       = hit_idx_r;
    ram_raddr       = scan_idx_r;
    gm_we           = 1'b0;

    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Evaluate the entry read back in the previous cycle.
    if (pipe_v_r) begin
      if (op_r == OP_CHECK) begin
        if (ent_valid && cmp_eq && (!best_found_r || (ram_rd.grp < best_grp_r))) begin
          best_found_nxt = 1'b1;
          best_grp_nxt   = ram_rd.grp;
          best_verd_nxt  = ram_rd.verdict;
        end
      end else begin
        if (ent_valid && !new_r && !hit_r && (ram_rd.grp == grp_r) && cmp_eq) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pipe_idx_r;
        end
        if (!ent_valid && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = pipe_idx_r;
        end
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          op_nxt         = in_req.operation;
          opa_nxt        = (in_req.operation == OP_ADD) ?
                           (in_req.address & in_req.rule_mask) : in_req.address;
          mask_nxt       = in_req.rule_mask;
          verd_nxt       = in_req.rule_verdict;
          best_found_nxt = 1'b0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          refused_nxt    = 1'b0;
          new_nxt        = 1'b0;
          scan_idx_nxt   = '0;
          g_idx_nxt      = '0;
          unique case (op_t'(in_req.operation))
            OP_CLEAR: begin
              valid_nxt = '0;
              count_nxt = '0;
              state_nxt = ST_RESP;
            end
            OP_ADD: begin
              if (count_r == '0) begin
                new_nxt   = 1'b1;
                grp_nxt   = '0;
                state_nxt = ST_ESCAN;
              end else begin
                state_nxt = ST_GSCAN;
              end
            end
            OP_CHECK: state_nxt = ST_ESCAN;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end

      ST_GSCAN: begin
        if (cmp_eq) begin
          grp_nxt   = g_idx_r;
          state_nxt = ST_ESCAN;
        end else if ((CNT_W'(g_idx_r) + CNT_W'(1)) == count_r) begin
          if (count_r == CNT_W'(MASK_GROUPS)) begin
            // group store full: drop the add
            refused_nxt = 1'b1;
            state_nxt   = ST_RESP;
          end else begin
            new_nxt   = 1'b1;
            grp_nxt   = count_r[GRP_W-1:0];
            state_nxt = ST_ESCAN;
          end
        end else begin
          g_idx_nxt = g_idx_r + GRP_W'(1);
        end
      end

      ST_ESCAN: begin
        pipe_v_nxt   = 1'b1;
        pipe_idx_nxt = scan_idx_r;
        if (scan_idx_r == IDX_W'(RULE_ENTRIES - 1)) begin
          state_nxt = ST_EDRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end

      ST_EDRAIN: begin
        pipe_v_nxt = 1'b0;
        state_nxt  = (op_r == OP_ADD) ? ST_WRITE : ST_RESP;
      end

      ST_WRITE: begin
        if (hit_r) begin
          ram_we    = 1'b1;
          ram_waddr = hit_idx_r;
        end else if (free_found_r) begin
          ram_we                = 1'b1;
          ram_waddr             = free_idx_r;
          valid_nxt[free_idx_r] = 1'b1;
          if (new_r) begin
            gm_we     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end else begin
          refused_nxt = 1'b1;
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = (op_r == OP_CHECK && best_found_r) ? best_verd_r : '0;
          out_matched_nxt = (op_r == OP_CHECK) && best_found_r;
          out_refused_nxt = (op_r == OP_ADD) && refused_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      valid_r      <= '0;
      pipe_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      new_r        <= 1'b0;
      best_found_r <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      refused_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      valid_r      <= valid_nxt;
      pipe_v_r     <= pipe_v_nxt;
      out_valid_r  <= out_valid_nxt;
      new_r        <= new_nxt;
      best_found_r <= best_found_nxt;
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
      refused_r    <= refused_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    opa_r         <= opa_nxt;
    mask_r        <= mask_nxt;
    verd_r        <= verd_nxt;
    g_idx_r       <= g_idx_nxt;
    grp_r         <= grp_nxt;
    scan_idx_r    <= scan_idx_nxt;
    pipe_idx_r    <= pipe_idx_nxt;
    best_grp_r    <= best_grp_nxt;
    best_verd_r   <= best_verd_nxt;
    hit_idx_r     <= hit_idx_nxt;
    free_idx_r    <= free_idx_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_matched_r <= out_matched_nxt;
    out_refused_r <= out_refused_nxt;
    if (gm_we) begin
      gm_r[grp_r] <= mask_r;
    end
  end

endmodule

/* test/tb_masked_address_filter_table.sv */
// Self-checking testbench for masked_address_filter_table: directed table, then random
// rule-building episodes; results checked against typed rows or a table predictor.
// Depends on mafl_pkg, mafl_if and the RTL top level.
module tb_masked_address_filter_table;
  import mafl_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
  localparam logic [VERD_W-1:0] VERD_NONE    = 2'd0;
  localparam logic [VERD_W-1:0] VERD_BANNED  = 2'd1;
  localparam logic [VERD_W-1:0] VERD_MUTED   = 2'd2;
  localparam logic [VERD_W-1:0] VERD_FLAGGED = 2'd3;
  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;

  localparam int RANDOM_ITEMS   = 1130;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_HOLDOFF    = 100;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] rule_mask;
    logic [VERD_W-1:0] rule_verdict;
  } req_t;

  typedef struct packed {
    logic [VERD_W-1:0] verdict;
    logic              matched;
    logic              refused;
  } res_t;

  typedef struct {
    req_t req;
    bit   typed;
    res_t res;
  } dir_row_t;

  typedef enum {RX_ALWAYS, RX_COIN, RX_RUNS} rx_mode_t;
  typedef enum {EP_FILL_ENTRIES, EP_FILL_GROUPS, EP_MIXED} episode_t;

  logic clk;
  logic rst_n;

  mafl_req_if in_req();
  mafl_res_if out_res();

  masked_address_filter_table u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted table contents
  logic [ADDR_W-1:0] grp_mask [MASK_GROUPS];
  int                grp_used;
  logic [ADDR_W-1:0] rule_key [RULE_ENTRIES];
  int                rule_grp [RULE_ENTRIES];
  logic [VERD_W-1:0] rule_verd [RULE_ENTRIES];
  bit                rule_used [RULE_ENTRIES];

  res_t     pending_results [$];
  dir_row_t directed_rows [$];
  int       fail_count;
  int       tx_burst_left;
  bit       tx_idle_on;

  function automatic res_t apply_request(input req_t r);
    res_t              res;
    logic [ADDR_W-1:0] key;
    int                g;
    int                slot;
    int                free_slot;
    bit                found;
    res = '0;
    g = 0;
    found = 1'b0;
    case (r.op)
      OP_CLEAR: begin
        grp_used = 0;
        for (int i = 0; i < RULE_ENTRIES; i++) rule_used[i] = 1'b0;
      end
      OP_ADD: begin
        key = r.address & r.rule_mask;
        for (int i = 0; i < grp_used; i++) begin
          if (!found && grp_mask[i] == r.rule_mask) begin
            found = 1'b1;
            g = i;
          end
        end
        slot = -1;
        free_slot = -1;
        for (int i = 0; i < RULE_ENTRIES; i++) begin
          if (found && slot < 0 && rule_used[i] && rule_grp[i] == g && rule_key[i] == key)
            slot = i;
          if (free_slot < 0 && !rule_used[i]) free_slot = i;
        end
        if (slot < 0) slot = free_slot;
        if ((!found && grp_used >= MASK_GROUPS) || slot < 0) begin
          res.refused = 1'b1;
        end else begin
          if (!found) begin
            g = grp_used;
            grp_mask[g] = r.rule_mask;
            grp_used++;
          end
          rule_key[slot]  = key;
          rule_grp[slot]  = g;
          rule_verd[slot] = r.rule_verdict;
          rule_used[slot] = 1'b1;
        end
      end
      OP_CHECK: begin
        // first group in creation order wins
        for (int gi = 0; gi < grp_used; gi++) begin
          for (int i = 0; i < RULE_ENTRIES; i++) begin
            if (!res.matched && rule_used[i] && rule_grp[i] == gi &&
                rule_key[i] == (r.address & grp_mask[gi])) begin
              res.verdict = rule_verd[i];
              res.matched = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] random_mask(input int min_len);
    int len;
    if ($urandom_range(0, 5) == 0) return $urandom;
    len = $urandom_range(min_len, ADDR_W);
    return {ADDR_W{1'b1}} << (ADDR_W - len);
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                  input logic [ADDR_W-1:0] mask,
                                  input logic [VERD_W-1:0] verd, input bit typed,
                                  input logic [VERD_W-1:0] exp_verd, input logic exp_match,
                                  input logic exp_refused);
    dir_row_t row;
    row.req   = '{op: op, address: addr, rule_mask: mask, rule_verdict: verd};
    row.typed = typed;
    row.res   = '{verdict: exp_verd, matched: exp_match, refused: exp_refused};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Drive one request, hold it until taken, then record what it should return.
  task automatic send_req(input req_t r, input bit typed, input res_t typed_res);
    res_t pred;
    if (tx_idle_on) begin
      if (tx_burst_left == 0) begin
        tx_burst_left = $urandom_range(1, 12);
        in_req.valid <= 1'b0;
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(20, 90)) @(posedge clk);
        else
          repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      tx_burst_left--;
    end
    in_req.valid        <= 1'b1;
    in_req.operation    <= r.op;
    in_req.address      <= r.address;
    in_req.rule_mask    <= r.rule_mask;
    in_req.rule_verdict <= r.rule_verdict;
    do @(posedge clk); while (!in_req.ready);
    pred = apply_request(r);
    pending_results.insert(pending_results.size(), typed ? typed_res : pred);
  endtask

  task automatic wait_results_drained();
    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Result checker and receiver stall pattern
  rx_mode_t rx_mode;
  int       rx_stall;
  int       rx_cycle;
  res_t     exp_res;

  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_res.verdict !== exp_res.verdict) begin
          $error("verdict: expected %0d, got %0d", exp_res.verdict, out_res.verdict);
          fail_count++;
        end
        if (out_res.matched !== exp_res.matched) begin
          $error("matched: expected %0d, got %0d", exp_res.matched, out_res.matched);
          fail_count++;
        end
        if (out_res.refused !== exp_res.refused) begin
          $error("refused: expected %0d, got %0d", exp_res.refused, out_res.refused);
          fail_count++;
        end
      end
    end
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
    case (rx_mode)
      RX_ALWAYS: out_res.ready <= 1'b1;
      RX_COIN:   out_res.ready <= ($urandom_range(0, 1) == 1);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          out_res.ready <= 1'b0;
        end else begin
          out_res.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) rx_stall = $urandom_range(1, 12);
        end
      end
    endcase
  end

  int idle_cycles;

  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    req_t              r;
    logic [ADDR_W-1:0] mask_pool [$];
    logic [ADDR_W-1:0] addr_pool [$];
    episode_t          kind;
    int                rand_sent;
    int                ep_len;
    int                n_masks;
    int                add_pct;
    int                pick;
    bit                paused_once;

    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_req.valid        = 1'b0;
    in_req.operation    = OP_CLEAR;
    in_req.address      = '0;
    in_req.rule_mask    = '0;
    in_req.rule_verdict = VERD_NONE;
    out_res.ready       = 1'b0;
    rx_mode             = RX_ALWAYS;
    fail_count          = 0;
    tx_idle_on          = 1'b0;
    tx_burst_left       = 0;
    rand_sent           = 0;
    paused_once         = 1'b0;

    // empty table, unused opcode, clear, then one exact-match rule
    add_row(OP_CHECK,  32'h0A00_0001, 32'hFFFF_FFFF, VERD_FLAGGED, TYPED, VERD_NONE, 0, 0);
    add_row(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, VERD_FLAGGED, TYPED, VERD_NONE, 0, 0);
    add_row(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, VERD_FLAGGED, TYPED, VERD_NONE, 0, 0);
    add_row(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, VERD_FLAGGED, TYPED, VERD_NONE, 0, 0);
    add_row(OP_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, VERD_NONE, TYPED, VERD_FLAGGED, 1, 0);
    add_row(OP_CHECK,  32'hFFFF_FFFE, 32'h0000_0000, VERD_NONE, TYPED, VERD_NONE, 0, 0);
    // stored verdict of zero still reports a match
    add_row(OP_ADD,    32'h0A0B_0C0D, 32'hFFFF_FF00, VERD_NONE, TYPED, VERD_NONE, 0, 0);
    add_row(OP_CHECK,  32'h0A0B_0CFF, 32'h0000_0000, VERD_NONE, TYPED, VERD_NONE, 1, 0);
    add_row(OP_ADD,    32'h1234_5678, 32'h0000_0000, VERD_BANNED, PREDICT, VERD_NONE, 0, 0);
    add_row(OP_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, VERD_NONE, PREDICT, VERD_NONE, 0, 0);
    add_row(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, VERD_MUTED, PREDICT, VERD_NONE, 0, 0);
    add_row(OP_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, VERD_NONE, PREDICT, VERD_NONE, 0, 0);
    // fill the group store, then one mask too many
    add_row(OP_ADD,    32'h8000_0000, 32'hF000_0000, VERD_MUTED, PREDICT, VERD_NONE, 0, 0);
    add_row(OP_ADD,    32'h00FF_0000, 32'hFF00_0000, VERD_BANNED, PREDICT, VERD_NONE, 0, 0);
    add_row(OP_ADD,    32'h5555_AAAA, 32'hFFFF_0000, VERD_FLAGGED, PREDICT, VERD_NONE, 0, 0);
    add_row(OP_ADD,    32'hAAAA_5555, 32'hFFFF_FFF0, VERD_BANNED, PREDICT, VERD_NONE, 0, 0);
    add_row(OP_ADD,    32'hC000_0000, 32'h8000_0000, VERD_MUTED, PREDICT, VERD_NONE, 0, 0);
    add_row(OP_ADD,    32'h0102_0304, 32'h00FF_00FF, VERD_BANNED, PREDICT, VERD_NONE, 0, 0);
    add_row(OP_CHECK,  32'h5555_FFFF, 32'h0000_0000, VERD_NONE, PREDICT, VERD_NONE, 0, 0);
    add_row(OP_CHECK,  32'h0102_0304, 32'h0000_0000, VERD_NONE, PREDICT, VERD_NONE, 0, 0);
    add_row(OP_CLEAR,  32'h0000_0000, 32'h0000_0000, VERD_NONE, TYPED, VERD_NONE, 0, 0);
    add_row(OP_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, VERD_NONE, TYPED, VERD_NONE, 0, 0);
    add_row(OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF, VERD_BANNED, PREDICT, VERD_NONE, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

    while (rand_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 3) ? EP_FILL_ENTRIES : (pick < 5) ? EP_FILL_GROUPS : EP_MIXED;
      tx_idle_on = ($urandom_range(0, 3) != 0);
      if (!paused_once || $urandom_range(0, 4) == 0) begin
        wait_results_drained();
        paused_once = 1'b1;
      end

      mask_pool.delete();
      addr_pool.delete();
      case (kind)
        EP_FILL_ENTRIES: begin
          n_masks = $urandom_range(1, 2);
          ep_len  = $urandom_range(110, 140);
          add_pct = 85;
        end
        EP_FILL_GROUPS: begin
          n_masks = $urandom_range(9, 12);
          ep_len  = $urandom_range(20, 40);
          add_pct = 55;
        end
        default: begin
          n_masks = $urandom_range(1, 5);
          ep_len  = $urandom_range(15, 50);
          add_pct = 50;
        end
      endcase
      for (int k = 0; k < n_masks; k++)
        mask_pool.insert(mask_pool.size(), random_mask(kind == EP_FILL_ENTRIES ? 16 : 0));

      if ($urandom_range(0, 7) != 0) begin
        r = '{op: OP_CLEAR, address: $urandom, rule_mask: $urandom,
              rule_verdict: VERD_W'($urandom_range(0, 3))};
        send_req(r, PREDICT, '0);
        rand_sent++;
      end

      repeat (ep_len) begin
        r.address      = $urandom;
        r.rule_mask    = $urandom;
        r.rule_verdict = VERD_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < add_pct) begin
          r.op = OP_ADD;
          // a fresh mask now and then: new group, or refused when a store is full
          if (pick < 4)
            r.rule_mask = random_mask(0);
          else
            r.rule_mask = mask_pool[$urandom_range(0, mask_pool.size() - 1)];
          if (addr_pool.size() != 0 && $urandom_range(0, 9) == 0)
            r.address = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
          else
            addr_pool.insert(addr_pool.size(), r.address);
        end else if (pick < 93) begin
          r.op = OP_CHECK;
          if (addr_pool.size() != 0) begin
            case ($urandom_range(0, 3))
              0, 1: r.address = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
              2: r.address = addr_pool[$urandom_range(0, addr_pool.size() - 1)] ^
                             {24'h0, 8'($urandom)};
              default: ;
            endcase
          end
        end else if (pick < 98) begin
          r.op = OP_UNUSED;
        end else begin
          r.op = OP_CLEAR;
        end
        send_req(r, PREDICT, '0);
        rand_sent++;
      end
    end

    wait_results_drained();
    repeat (END_HOLDOFF) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
